// ----- design/cdq_pkg.sv -----
// Shared types and codes for the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

    typedef enum logic [2:0] {
        ACT_PUSH_HEAD = 3'd0,
        ACT_PUSH_TAIL = 3'd1,
        ACT_POP_HEAD  = 3'd2,
        ACT_POP_TAIL  = 3'd3,
        ACT_PEEK_HEAD = 3'd4,
        ACT_PEEK_TAIL = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_SHIFT_IN  = 2'd1,
        CELL_SHIFT_OUT = 2'd2,
        CELL_WRITE_AT  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic signed [31:0] value;
    } t_chain_ctl;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] data;
        t_status            status;
        logic [7:0]         count_after;
        logic               is_empty;
        logic               is_full;
    } t_rsp;

endpackage

// ----- design/cdq_cell.sv -----
// One storage cell of a deque chain: shift toward either neighbor or load at its own position.
`timescale 1ns / 1ps

module cdq_cell #(
    parameter int CW  = 8,
    parameter int IDX = 0
) (
    input  logic                      i_clk,
    input  cdq_pkg::t_chain_ctl       i_ctl,
    input  logic [CW-1:0]             i_count,
    input  logic signed [31:0]        i_left,
    input  logic signed [31:0]        i_right,
    output logic signed [31:0]        o_data
);

    localparam logic [CW-1:0] L_IDX = CW'(IDX);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            cdq_pkg::CELL_SHIFT_IN:  n_data = i_left;
            cdq_pkg::CELL_SHIFT_OUT: n_data = i_right;
            cdq_pkg::CELL_WRITE_AT: begin
                if (i_count == L_IDX) begin
                    n_data = i_ctl.value;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ----- design/cdq_chain.sv -----
// Row of deque cells, end word at cell 0.
`timescale 1ns / 1ps

module cdq_chain #(
    parameter int DEPTH = 128,
    parameter int CW    = 8
) (
    input  logic                i_clk,
    input  cdq_pkg::t_chain_ctl i_ctl,
    input  logic [CW-1:0]       i_count,
    output logic signed [31:0]  o_end
);

    logic signed [31:0] w_data [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] w_left;
        logic signed [31:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_ctl.value;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        cdq_cell #(
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_count (i_count),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g])
        );
    end

    assign o_end = w_data[0];

endmodule

// ----- design/circular_deque.sv -----
// Top level of the deque: request decode, word count, two cell chains and result register.
//
//   channel   valid        ready        payload
//   request   i_in_valid   o_in_ready   i_in_data  (cdq_pkg::t_req)
//   result    o_out_valid  i_out_ready  o_out_data (cdq_pkg::t_rsp)
//
// One request per cycle while the result register is empty or being drained; its result is
// registered and shows in the cycle after acceptance. The front chain keeps the front word at
// its cell 0, the back chain the back word. Requests are taken whenever the result register is empty or being drained.
// Reset clears the word count and the result valid; cell contents are left as they are.
`timescale 1ns / 1ps

module circular_deque #(
    parameter int DEPTH = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  cdq_pkg::t_req   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output cdq_pkg::t_rsp   o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    cdq_pkg::t_rsp       r_out_data;
    cdq_pkg::t_rsp       n_out_data;
    cdq_pkg::t_chain_ctl w_front_ctl;
    cdq_pkg::t_chain_ctl w_back_ctl;
    logic signed [31:0]  w_front_word;
    logic signed [31:0]  w_back_word;
    logic                w_accept;
    logic                w_empty;
    logic                w_full;
    logic [CW+7:0]       w_count_ext;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CW'(DEPTH));

    always_comb begin
        logic signed [31:0] v_data;
        cdq_pkg::t_status   v_status;
        v_data            = '0;
        v_status          = cdq_pkg::ST_OK;
        n_count           = r_count;
        w_front_ctl.op    = cdq_pkg::CELL_HOLD;
        w_front_ctl.value = i_in_data.value;
        w_back_ctl.op     = cdq_pkg::CELL_HOLD;
        w_back_ctl.value  = i_in_data.value;
        case (i_in_data.action)
            cdq_pkg::ACT_PUSH_HEAD, cdq_pkg::ACT_PUSH_TAIL: begin
                if (w_full) begin
                    v_status = cdq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                    if (i_in_data.action == cdq_pkg::ACT_PUSH_HEAD) begin
                        w_front_ctl.op = cdq_pkg::CELL_SHIFT_IN;
                        w_back_ctl.op  = cdq_pkg::CELL_WRITE_AT;
                    end else begin
                        w_front_ctl.op = cdq_pkg::CELL_WRITE_AT;
                        w_back_ctl.op  = cdq_pkg::CELL_SHIFT_IN;
                    end
                end
            end
            cdq_pkg::ACT_POP_HEAD: begin
                if (w_empty) begin
                    v_status = cdq_pkg::ST_EMPTY;
                end else begin
                    v_data         = w_front_word;
                    n_count        = r_count - CW'(1);
                    w_front_ctl.op = cdq_pkg::CELL_SHIFT_OUT;
                end
            end
            cdq_pkg::ACT_POP_TAIL: begin
                if (w_empty) begin
                    v_status = cdq_pkg::ST_EMPTY;
                end else begin
                    v_data        = w_back_word;
                    n_count       = r_count - CW'(1);
                    w_back_ctl.op = cdq_pkg::CELL_SHIFT_OUT;
                end
            end
            cdq_pkg::ACT_PEEK_HEAD: begin
                if (w_empty) begin
                    v_status = cdq_pkg::ST_EMPTY;
                end else begin
                    v_data = w_front_word;
                end
            end
            cdq_pkg::ACT_PEEK_TAIL: begin
                if (w_empty) begin
                    v_status = cdq_pkg::ST_EMPTY;
                end else begin
                    v_data = w_back_word;
                end
            end
            default: begin
                v_status = cdq_pkg::ST_OK;
            end
        endcase
        if (!w_accept) begin
            w_front_ctl.op = cdq_pkg::CELL_HOLD;
            w_back_ctl.op  = cdq_pkg::CELL_HOLD;
        end
        w_count_ext            = {8'b0, n_count};
        n_out_data.data        = v_data;
        n_out_data.status      = v_status;
        n_out_data.count_after = w_count_ext[7:0];
        n_out_data.is_empty    = (n_count == '0);
        n_out_data.is_full     = (n_count == CW'(DEPTH));
    end

    cdq_chain #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_front (
        .i_clk   (i_clk),
        .i_ctl   (w_front_ctl),
        .i_count (r_count),
        .o_end   (w_front_word)
    );

    cdq_chain #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_back (
        .i_clk   (i_clk),
        .i_ctl   (w_back_ctl),
        .i_count (r_count),
        .o_end   (w_back_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
